// ===== rtl/core/mecanum_wheel_mixer_macros.svh =====
// assertion macros for the mecanum wheel mixer
// included by the top level; depends on nothing else
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, switched off while reset is high
`define MWM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property, also checked through reset
`define MWM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MWM_ASSERT(label, clk, rst, prop, msg)
`define MWM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/mwm_pkg.sv =====
// shared types and constants of the mecanum wheel mixer
// used by mwm_mix, mwm_lane and mecanum_wheel_mixer; depends on nothing
package mwm_pkg;

  localparam int DUTY_W     = 16;
  localparam int LIM_W      = 15;
  localparam int NUM_WHEELS = 4;
  // one quotient bit per divider stage
  localparam int STEPS      = LIM_W;
  localparam int PROD_W     = DUTY_W + LIM_W;
  // mix, max, multiply, divider steps, output select
  localparam int PIPE_DEPTH = 3 + STEPS + 1;

  // register indexes (byte address bit 2)
  localparam logic REG_DUTY_LIMIT = 1'b0;
  localparam logic REG_NORM_EN    = 1'b1;

  localparam logic [LIM_W-1:0] DUTY_LIMIT_RST = 15'h7FFF;

  typedef logic signed [DUTY_W-1:0] duty_t;
  typedef logic        [DUTY_W-1:0] mag_t;

  typedef struct packed {
    logic [LIM_W-1:0] lim;
    logic             en;
  } cfg_t;

  typedef struct packed {
    duty_t [NUM_WHEELS-1:0] duty;
    mag_t  [NUM_WHEELS-1:0] mag;
    mag_t                   mx;
  } mix_t;

endpackage

// ===== rtl/core/mwm_mix.sv =====
// front end: wheel mix with saturation, then magnitudes and their maximum
// two register stages; depends on mwm_pkg
module mwm_mix (
  input  logic                 clk,
  input  logic                 adv,
  input  mwm_pkg::duty_t       vel_x,
  input  mwm_pkg::duty_t       vel_y,
  input  mwm_pkg::duty_t       yaw_rate,
  output mwm_pkg::mix_t        mix
);

  function automatic mwm_pkg::duty_t sat16(input logic signed [17:0] s);
    if (s > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (s < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return s[15:0];
    end
  endfunction

  logic signed [17:0] vx, vy, wz;
  mwm_pkg::duty_t [mwm_pkg::NUM_WHEELS-1:0] duty;
  mwm_pkg::mag_t  [mwm_pkg::NUM_WHEELS-1:0] mag_c;
  mwm_pkg::mag_t  max01, max23, mx_c;

  assign vx = 18'(vel_x);
  assign vy = 18'(vel_y);
  assign wz = 18'(yaw_rate);

  // stage 1: exact sums, saturated to 16 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      duty[0] <= sat16(vx - vy - wz);
      duty[1] <= sat16(vx + vy + wz);
      duty[2] <= sat16(vx - vy + wz);
      duty[3] <= sat16(vx + vy - wz);
    end
  end

  // magnitudes; the most negative duty gives 32768, which still fits
  always_comb begin
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      mag_c[i] = duty[i][15] ? mwm_pkg::mag_t'(-duty[i]) : mwm_pkg::mag_t'(duty[i]);
    end
    max01 = (mag_c[1] > mag_c[0]) ? mag_c[1] : mag_c[0];
    max23 = (mag_c[3] > mag_c[2]) ? mag_c[3] : mag_c[2];
    mx_c  = (max23 > max01) ? max23 : max01;
  end

  // stage 2: duties, magnitudes and largest magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      mix.duty <= duty;
      mix.mag  <= mag_c;
      mix.mx   <= mx_c;
    end
  end

endmodule

// ===== rtl/core/mwm_lane.sv =====
// one wheel lane: scale decision, multiply by the limit, restoring divide
// by the largest magnitude one bit a stage, then sign and select; uses mwm_pkg
module mwm_lane (
  input  logic           clk,
  input  logic           adv,
  input  mwm_pkg::cfg_t  cfg,
  input  mwm_pkg::duty_t duty,
  input  mwm_pkg::mag_t  mag,
  input  mwm_pkg::mag_t  mx,
  output mwm_pkg::duty_t result
);

  localparam int S = mwm_pkg::STEPS;

  logic [mwm_pkg::DUTY_W-1:0] rem  [0:S];
  logic [S-1:0]               low  [0:S];
  logic [S-1:0]               quo  [0:S];
  mwm_pkg::mag_t              dvs  [0:S];
  mwm_pkg::duty_t             dty  [0:S];
  logic                       scl  [0:S];
  logic [mwm_pkg::DUTY_W:0]   qext;

  // multiply stage: product splits into the first partial remainder and
  // the dividend bits still to come
  always_ff @(posedge clk) begin
    if (adv) begin
      {rem[0], low[0]} <= mwm_pkg::PROD_W'(mag) * mwm_pkg::PROD_W'(cfg.lim);
      quo[0] <= '0;
      dvs[0] <= mx;
      dty[0] <= duty;
      scl[0] <= cfg.en && (cfg.lim != '0) && (mx > mwm_pkg::mag_t'(cfg.lim));
    end
  end

  // divider stages, one quotient bit each
  for (genvar k = 1; k <= S; k++) begin : g_step
    logic [mwm_pkg::DUTY_W:0] trial;
    logic [mwm_pkg::DUTY_W:0] diff;
    logic                     ge;

    assign trial = {rem[k-1], low[k-1][S-1]};
    assign diff  = trial - (mwm_pkg::DUTY_W+1)'(dvs[k-1]);
    assign ge    = trial >= (mwm_pkg::DUTY_W+1)'(dvs[k-1]);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge ? diff[mwm_pkg::DUTY_W-1:0] : trial[mwm_pkg::DUTY_W-1:0];
        low[k] <= {low[k-1][S-2:0], 1'b0};
        quo[k] <= {quo[k-1][S-2:0], ge};
        dvs[k] <= dvs[k-1];
        dty[k] <= dty[k-1];
        scl[k] <= scl[k-1];
      end
    end
  end

  // quotient magnitude takes the duty's sign, truncating toward zero
  assign qext = (mwm_pkg::DUTY_W+1)'(quo[S]);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (scl[S]) begin
        result <= dty[S][mwm_pkg::DUTY_W-1] ? mwm_pkg::duty_t'(-qext)
                                            : mwm_pkg::duty_t'(qext);
      end else begin
        result <= dty[S];
      end
    end
  end

endmodule

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// mecanum wheel mixer top level: an accepted item passes through two mix stages,
// the multiply, the 15-stage divider and the output register before its result is
// shown; throughput one item per cycle while the output is not stalled, as every stage is
// pipelined. a stalled output freezes the whole pipeline.
// reset clears the valid bits and loads duty_limit 32767, normalize_enable 1.
// depends on mwm_pkg, mwm_mix, mwm_lane and mecanum_wheel_mixer_macros.svh
`include "mecanum_wheel_mixer_macros.svh"
module mecanum_wheel_mixer (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mwm_pkg::duty_t       vel_x,
  input  mwm_pkg::duty_t       vel_y,
  input  mwm_pkg::duty_t       yaw_rate,
  // duty channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output mwm_pkg::duty_t       motor1_duty,
  output mwm_pkg::duty_t       motor2_duty,
  output mwm_pkg::duty_t       motor3_duty,
  output mwm_pkg::duty_t       motor4_duty,
  output logic                 status,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int D = mwm_pkg::PIPE_DEPTH;

  mwm_pkg::cfg_t  cfg;
  mwm_pkg::mix_t  mix;
  mwm_pkg::duty_t [mwm_pkg::NUM_WHEELS-1:0] res;
  logic [D-1:0]   vld;
  logic [D-1:0]   stat;
  logic           adv;
  logic           wr;
  logic signed [mwm_pkg::DUTY_W-1:0] lim_s;

  // register port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lim <= mwm_pkg::DUTY_LIMIT_RST;
      cfg.en  <= 1'b1;
    end else if (wr) begin
      case (paddr[2])
        mwm_pkg::REG_DUTY_LIMIT: cfg.lim <= pwdata[mwm_pkg::LIM_W-1:0];
        mwm_pkg::REG_NORM_EN:    cfg.en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mwm_pkg::REG_DUTY_LIMIT: prdata = 32'(cfg.lim);
      mwm_pkg::REG_NORM_EN:    prdata = 32'(cfg.en);
      default:                 prdata = '0;
    endcase
  end

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // valid bits and status travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stat <= {stat[D-2:0], cfg.en && (cfg.lim == '0)};
    end
  end

  mwm_mix u_mix (
    .clk      (clk),
    .adv      (adv),
    .vel_x    (vel_x),
    .vel_y    (vel_y),
    .yaw_rate (yaw_rate),
    .mix      (mix)
  );

  // one scaling lane per wheel
  for (genvar w = 0; w < mwm_pkg::NUM_WHEELS; w++) begin : g_lane
    mwm_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .cfg    (cfg),
      .duty   (mix.duty[w]),
      .mag    (mix.mag[w]),
      .mx     (mix.mx),
      .result (res[w])
    );
  end

  assign out_valid   = vld[D-1];
  assign status      = stat[D-1];
  assign motor1_duty = res[0];
  assign motor2_duty = res[1];
  assign motor3_duty = res[2];
  assign motor4_duty = res[3];

  assign lim_s = mwm_pkg::DUTY_W'(cfg.lim);

  // checks
  `MWM_ASSERT(a_stall_freezes_pipe, clk, rst, !in_ready |=> $stable(vld),
              "valid bits moved during a stall")
  `MWM_ASSERT(a_status_source, clk, rst,
              out_valid && status |-> cfg.en && (cfg.lim == '0),
              "status raised with a usable limit")
  `MWM_ASSERT(a_duty_within_limit, clk, rst,
              out_valid && cfg.en && (cfg.lim != '0) |->
              (motor1_duty <= lim_s) && (motor1_duty >= -lim_s) &&
              (motor2_duty <= lim_s) && (motor2_duty >= -lim_s) &&
              (motor3_duty <= lim_s) && (motor3_duty >= -lim_s) &&
              (motor4_duty <= lim_s) && (motor4_duty >= -lim_s),
              "normalised duty beyond the limit")
  `MWM_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid,
                     "result shown straight after reset")

endmodule

// ===== verif/mecanum_wheel_mixer_tb.sv =====
// self-checking testbench for the mecanum wheel mixer: random bursty commands,
// a stalling duty sink, register writes between phases and a scoreboard class
// depends on mwm_pkg and the mecanum_wheel_mixer rtl
module mecanum_wheel_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int ITEMS_PER_SET = 250;

  typedef struct packed {
    mwm_pkg::duty_t [mwm_pkg::NUM_WHEELS-1:0] duty;
    logic                                     status;
  } wheel_duties_t;

  // mixer predictor and queue of duty sets still owed by the block
  class wheel_scoreboard;
    logic [mwm_pkg::LIM_W-1:0] duty_limit = mwm_pkg::DUTY_LIMIT_RST;
    logic                      norm_en    = 1'b1;
    wheel_duties_t             owed_q[$];
    int                        commands   = 0;
    int                        checked    = 0;
    int                        failures   = 0;

    function void set_register(logic reg_sel, logic [31:0] value);
      if (reg_sel == mwm_pkg::REG_DUTY_LIMIT) begin
        duty_limit = value[mwm_pkg::LIM_W-1:0];
      end else begin
        norm_en = value[0];
      end
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // mix, saturate, then scale to the limit keeping wheel ratios
    function wheel_duties_t mix_command(int vx, int vy, int wz);
      int            d[mwm_pkg::NUM_WHEELS];
      int            mx;
      int            lim;
      wheel_duties_t r;
      d[0] = clamp16(vx - vy - wz);
      d[1] = clamp16(vx + vy + wz);
      d[2] = clamp16(vx - vy + wz);
      d[3] = clamp16(vx + vy - wz);
      r.status = 1'b0;
      if (norm_en) begin
        if (duty_limit == 0) begin
          r.status = 1'b1;
        end else begin
          lim = int'(duty_limit);
          mx  = 0;
          for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
            if ((d[i] < 0 ? -d[i] : d[i]) > mx) mx = (d[i] < 0 ? -d[i] : d[i]);
          end
          if (mx > lim) begin
            for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
              d[i] = int'((longint'(d[i]) * lim) / mx);
            end
          end
        end
      end
      for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) r.duty[i] = mwm_pkg::duty_t'(d[i]);
      return r;
    endfunction

    function void note_command(mwm_pkg::duty_t vx, mwm_pkg::duty_t vy, mwm_pkg::duty_t wz);
      owed_q.push_back(mix_command(int'(vx), int'(vy), int'(wz)));
      commands++;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_duties(wheel_duties_t got);
      wheel_duties_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("duty set with nothing owed: %0d %0d %0d %0d status %0b",
                         got.duty[0], got.duty[1], got.duty[2], got.duty[3], got.status));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
        if (got.duty[i] !== want.duty[i]) begin
          report($sformatf("result %0d motor%0d_duty expected %0d got %0d",
                           checked, i + 1, want.duty[i], got.duty[i]));
        end
      end
      if (got.status !== want.status) begin
        report($sformatf("result %0d status expected %0b got %0b",
                         checked, want.status, got.status));
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  mwm_pkg::duty_t vel_x = '0;
  mwm_pkg::duty_t vel_y = '0;
  mwm_pkg::duty_t yaw_rate = '0;
  logic           out_valid;
  logic           out_ready = 1'b1;
  mwm_pkg::duty_t motor1_duty;
  mwm_pkg::duty_t motor2_duty;
  mwm_pkg::duty_t motor3_duty;
  mwm_pkg::duty_t motor4_duty;
  logic           status;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  wheel_scoreboard sb;
  int cycle_count = 0;
  int settings_used = 0;
  int burst_left = 0;
  int sink_mode = 0;
  int sink_mode_left = 0;
  int sink_stall_run = 0;

  mecanum_wheel_mixer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .motor1_duty(motor1_duty), .motor2_duty(motor2_duty),
    .motor3_duty(motor3_duty), .motor4_duty(motor4_duty),
    .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d duty sets still owed", cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // duty sink: checks accepted items and stalls in modes of its own
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_duties({motor4_duty, motor3_duty, motor2_duty, motor1_duty, status});
    end
    if (sink_mode_left == 0) begin
      sink_mode      <= $urandom_range(0, 2);
      sink_mode_left <= $urandom_range(20, 200);
    end else begin
      sink_mode_left <= sink_mode_left - 1;
    end
    case (sink_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (sink_stall_run > 0) begin
          out_ready      <= 1'b0;
          sink_stall_run <= sink_stall_run - 1;
        end else if ($urandom_range(0, 5) == 0) begin
          out_ready      <= 1'b0;
          sink_stall_run <= $urandom_range(1, 8);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // present one command and hold it until accepted
  task automatic send_command(input int vx, input int vy, input int wz);
    vel_x    <= mwm_pkg::duty_t'(vx);
    vel_y    <= mwm_pkg::duty_t'(vy);
    yaw_rate <= mwm_pkg::duty_t'(wz);
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(vel_x, vel_y, yaw_rate);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(reg_sel, value);
  endtask

  // let the pipeline empty, then load a new register setting
  task automatic set_mixer(input int limit, input logic enable);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    apb_write(mwm_pkg::REG_DUTY_LIMIT, 32'(limit));
    apb_write(mwm_pkg::REG_NORM_EN, {31'b0, enable});
    settings_used++;
  endtask

  function automatic int pick_velocity();
    logic signed [15:0] r;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 5))
          0: return -32768;
          1: return -32767;
          2: return -1;
          3: return 0;
          4: return 1;
          default: return 32767;
        endcase
      end
      2, 3, 4: return int'($urandom_range(0, 4000)) - 2000;
      default: begin
        r = $urandom();
        return r;
      end
    endcase
  endfunction

  // random commands in bursts with idle gaps between most of them
  task automatic random_commands(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_command(pick_velocity(), pick_velocity(), pick_velocity());
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: zero, full-scale and saturating commands
    send_command(0, 0, 0);
    send_command(32767, 32767, 32767);
    send_command(-32768, -32768, -32768);
    send_command(-32768, 32767, 0);
    send_command(32767, -32768, 0);
    send_command(1, -1, 1);
    send_command(0, 0, -32768);

    // small limit: within the limit, scaled, and a largest duty of 32768
    set_mixer(1000, 1'b1);
    send_command(100, 50, 25);
    send_command(20000, -5000, 3000);
    send_command(-32768, 0, 0);
    send_command(32767, 0, 32767);

    // zero limit with scaling enabled reports the bad limit
    set_mixer(0, 1'b1);
    send_command(5, 5, 5);
    send_command(-32768, 32767, -32768);

    // limit of one
    set_mixer(1, 1'b1);
    send_command(3, 2, 1);
    send_command(-1, 0, 0);
    send_command(2, 0, 0);

    // scaling disabled ignores the limit
    set_mixer(5, 1'b0);
    send_command(1000, -2000, 300);
    send_command(32767, 32767, -32768);

    // random phases over several register settings
    set_mixer(32767, 1'b1);
    random_commands(ITEMS_PER_SET);
    set_mixer(1, 1'b1);
    random_commands(ITEMS_PER_SET);
    set_mixer(0, 1'b1);
    random_commands(ITEMS_PER_SET);
    set_mixer($urandom_range(1, 32766), 1'b1);
    random_commands(ITEMS_PER_SET);
    set_mixer($urandom_range(0, 32767), 1'b0);
    random_commands(ITEMS_PER_SET);
    set_mixer(0, 1'b0);
    random_commands(ITEMS_PER_SET);
    set_mixer($urandom_range(1, 200), 1'b1);
    random_commands(ITEMS_PER_SET);
    set_mixer(32767, 1'b1);
    random_commands(ITEMS_PER_SET);

    // drain and watch for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (mwm_pkg::PIPE_DEPTH + 4) @(posedge clk);

    $display("mixer run: %0d commands under %0d register settings after reset",
             sb.commands, settings_used);
    $display("%0d duty sets checked, %0d failures", sb.checked, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
